// ----- rtl/pva_pkg.sv -----
// Shared types and constants for the polyphonic voice allocator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package pva_pkg;

    localparam int PAD_W          = 8;
    localparam int VALUE_W        = 9;
    localparam int VOICE_W        = 6;
    localparam int CFG_W          = 6;
    localparam int OUT_VALUE_W    = 8;
    localparam int DEF_MAX_VOICES = 48;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [CFG_W-1:0]          RESET_VOICES = CFG_W'(48);
    localparam logic signed [VALUE_W-1:0] NO_VALUE     = -VALUE_W'(1);

    typedef enum logic [1:0] {
        OP_SET_VALUE = 2'd0,
        OP_PAD_HELD  = 2'd1,
        OP_PAD_OWN   = 2'd2
    } t_opcode;

    // A pad event after the front has resolved which value it carries.
    typedef struct packed {
        logic [PAD_W-1:0]          pad;
        logic signed [VALUE_W-1:0] value;
    } t_event;

endpackage

`default_nettype wire

// ----- rtl/pva_front.sv -----
// Front end of the voice allocator: takes commands, keeps the held value and
// turns pad commands into resolved events. Depends on pva_pkg.
`default_nettype none

module pva_front
    import pva_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [1:0]                i_opcode,
    input  wire logic [PAD_W-1:0]          i_pad,
    input  wire logic signed [VALUE_W-1:0] i_value,
    input  wire logic                      i_full,
    output logic                           o_busy,
    output logic                           o_push,
    output t_event                         o_event
);

    logic signed [VALUE_W-1:0] r_held;
    logic signed [VALUE_W-1:0] n_held;
    logic                      accept;

    assign o_busy = i_full;
    assign accept = i_start && !i_full;

    always_comb begin
        n_held        = r_held;
        o_push        = 1'b0;
        o_event.pad   = i_pad;
        o_event.value = i_value;
        if (accept) begin
            case (t_opcode'(i_opcode))
                OP_SET_VALUE: begin
                    n_held = i_value;
                end
                OP_PAD_HELD: begin
                    o_push        = 1'b1;
                    o_event.value = r_held;
                    n_held        = NO_VALUE;
                end
                OP_PAD_OWN: begin
                    o_push = 1'b1;
                    n_held = NO_VALUE;
                end
                default: begin
                    n_held = r_held;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= NO_VALUE;
        end else begin
            r_held <= n_held;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/pva_queue.sv -----
// Short event queue between the front end and the voice table.
// Depends on pva_pkg for the event type and the queue depth.
`default_nettype none

module pva_queue
    import pva_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_event    i_event,
    input  wire logic i_pop,
    output logic      o_empty,
    output logic      o_full,
    output t_event    o_head
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_event          r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [PW-1:0]   n_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic            do_push;
    logic            do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_event;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/pva_back.sv -----
// Back end of the voice allocator: voice table, pad match and free-voice search,
// table update and the result register. Depends on pva_pkg.
`default_nettype none

module pva_back
    import pva_pkg::*;
#(
    parameter int MAX_VOICES = DEF_MAX_VOICES
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [CFG_W-1:0] i_active,
    input  wire logic             i_empty,
    input  t_event                i_head,
    output logic                  o_pop,
    output logic                  o_done,
    output logic [VOICE_W-1:0]    o_voice,
    output logic [PAD_W-1:0]      o_pad_out,
    output logic [OUT_VALUE_W-1:0] o_value_out
);

    localparam int IW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_APPLY = 2'b10
    } t_back_state;

    t_back_state             r_state;
    t_back_state             n_state;
    logic [MAX_VOICES-1:0]   r_vld;
    logic [PAD_W-1:0]        r_pad [MAX_VOICES];
    logic [MAX_VOICES-1:0]   r_hit;
    logic [MAX_VOICES-1:0]   r_free;
    logic [MAX_VOICES-1:0]   in_use;
    t_event                  r_ev;
    logic [IW-1:0]           hit_idx;
    logic [IW-1:0]           free_idx;
    logic [IW-1:0]           sel_idx;
    logic [8:0]              sel_wide;
    logic                    found;
    logic                    release_ev;
    logic                    tbl_we;
    logic                    r_done;
    logic                    n_done;
    logic [VOICE_W-1:0]      r_voice;
    logic [PAD_W-1:0]        r_pad_out;
    logic [OUT_VALUE_W-1:0]  r_value_out;

    // Entries at or above the configured count are neither searched nor claimed.
    always_comb begin
        for (int i = 0; i < MAX_VOICES; i++) begin
            in_use[i] = (9'(i) < 9'(i_active));
        end
    end

    // Lowest matching and lowest free entry.
    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = MAX_VOICES - 1; i >= 0; i--) begin
            if (r_hit[i]) begin
                hit_idx = IW'(i);
            end
            if (r_free[i]) begin
                free_idx = IW'(i);
            end
        end
    end

    assign found      = (|r_hit) || (|r_free);
    assign sel_idx    = (|r_hit) ? hit_idx : free_idx;
    assign sel_wide   = 9'(sel_idx);
    assign release_ev = (r_ev.value == '0);
    assign tbl_we     = r_state[1] && found;
    assign o_pop      = (r_state == S_IDLE) && !i_empty;

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                n_state = S_IDLE;
                n_done  = found && !r_ev.value[VALUE_W-1];
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_vld   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (tbl_we) begin
                // A release frees the voice even when it was claimed just now.
                r_vld[sel_idx] <= !release_ev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ev <= i_head;
            for (int i = 0; i < MAX_VOICES; i++) begin
                r_hit[i]  <= r_vld[i] && (r_pad[i] == i_head.pad) && in_use[i];
                r_free[i] <= !r_vld[i] && in_use[i];
            end
        end
        if (tbl_we) begin
            r_pad[sel_idx] <= r_ev.pad;
        end
        if (n_done) begin
            r_voice     <= sel_wide[VOICE_W-1:0];
            r_pad_out   <= r_ev.pad;
            r_value_out <= r_ev.value[OUT_VALUE_W-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_voice     = r_voice;
    assign o_pad_out   = r_pad_out;
    assign o_value_out = r_value_out;

endmodule

`default_nettype wire

// ----- rtl/poly_voice_allocator.sv -----
// Polyphonic voice allocator, top level: configuration register, front end,
// event queue and voice table. Depends on pva_pkg, pva_front, pva_queue, pva_back.
`default_nettype none

// A set-value command produces nothing. Each pad command is queued and then
// handled by the voice table: first the pad is compared against every voice
// and the free voices are found, then the lowest matching voice, else the
// lowest free one, is picked, the table is updated and, if a voice was found
// and the value is non-negative, the result is registered. The table takes no
// new pad event until the current one is applied. The two-entry queue in front
// of the table lets commands keep arriving; busy rises only when it is full.
// The result strobe o_done is high for exactly one cycle and the receiver
// cannot stall it, so results must be captured when they appear. Configuration
// writes are meant for times when no pad event is queued or in the table.
module poly_voice_allocator
    import pva_pkg::*;
#(
    parameter int MAX_VOICES = DEF_MAX_VOICES
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [1:0]                i_opcode,
    input  wire logic [PAD_W-1:0]          i_pad,
    input  wire logic signed [VALUE_W-1:0] i_value,
    input  wire logic                      i_cfg_we,
    input  wire logic [CFG_W-1:0]          i_cfg_data,
    output logic                           o_done,
    output logic [VOICE_W-1:0]             o_voice,
    output logic [PAD_W-1:0]               o_pad_out,
    output logic [OUT_VALUE_W-1:0]         o_value_out
);

    logic [CFG_W-1:0] r_active;
    logic             push;
    t_event           push_event;
    t_event           head;
    logic             pop;
    logic             empty;
    logic             full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= RESET_VOICES;
        end else if (i_cfg_we) begin
            r_active <= i_cfg_data;
        end
    end

    pva_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_pad    (i_pad),
        .i_value  (i_value),
        .i_full   (full),
        .o_busy   (busy),
        .o_push   (push),
        .o_event  (push_event)
    );

    pva_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_event (push_event),
        .i_pop   (pop),
        .o_empty (empty),
        .o_full  (full),
        .o_head  (head)
    );

    pva_back #(
        .MAX_VOICES (MAX_VOICES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_active    (r_active),
        .i_empty     (empty),
        .i_head      (head),
        .o_pop       (pop),
        .o_done      (o_done),
        .o_voice     (o_voice),
        .o_pad_out   (o_pad_out),
        .o_value_out (o_value_out)
    );

endmodule

`default_nettype wire

// ----- rtl/pva_checker.sv -----
// Port-level assertions for the polyphonic voice allocator, bound to the top level.
// Depends on pva_pkg and on the port names of poly_voice_allocator.
`default_nettype none

module pva_checker
    import pva_pkg::*;
#(
    parameter int MAX_VOICES = DEF_MAX_VOICES
) (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               busy,
    input wire logic               o_done,
    input wire logic [VOICE_W-1:0] o_voice
);

    // Reset empties the queue and drops any pending result.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done && !busy)
        else $error("result strobe or busy still set after reset");

    // The table needs a search step before each result, so strobes never touch.
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("results in two consecutive cycles");

    // A reported voice lies inside the table.
    a_voice_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (MAX_VOICES > 64) || (32'(o_voice) < MAX_VOICES))
        else $error("voice index beyond the table");

endmodule

bind poly_voice_allocator pva_checker #(.MAX_VOICES(MAX_VOICES)) u_pva_checker (.*);

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for poly_voice_allocator: a queue-fed command driver, a
// result monitor and a behavioral model of the voice table and held value.
// Depends on pva_pkg and the RTL of the block.
module tb;
    import pva_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [1:0]                opcode;
        logic [PAD_W-1:0]          pad;
        logic signed [VALUE_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic [VOICE_W-1:0]     voice;
        logic [PAD_W-1:0]       pad;
        logic [OUT_VALUE_W-1:0] value;
    } t_note;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic [1:0]                    i_opcode = '0;
    logic [PAD_W-1:0]              i_pad = '0;
    logic signed [VALUE_W-1:0]     i_value = '0;
    logic                          i_cfg_we = 1'b0;
    logic [CFG_W-1:0]              i_cfg_data = '0;
    logic                          o_done;
    logic [VOICE_W-1:0]            o_voice;
    logic [PAD_W-1:0]              o_pad_out;
    logic [OUT_VALUE_W-1:0]        o_value_out;

    poly_voice_allocator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_opcode    (i_opcode),
        .i_pad       (i_pad),
        .i_value     (i_value),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_done      (o_done),
        .o_voice     (o_voice),
        .o_pad_out   (o_pad_out),
        .o_value_out (o_value_out)
    );

    // Model state: which voices are claimed, by which pad, and the held value.
    logic                      voice_claimed [DEF_MAX_VOICES];
    logic [PAD_W-1:0]          voice_pad [DEF_MAX_VOICES];
    logic signed [VALUE_W-1:0] held_val;
    logic [CFG_W-1:0]          voice_count;

    t_cmd  cmd_queue[$];
    t_note notes_due[$];
    t_cmd  cur_cmd;
    t_note seen_note;
    int    gap_left = 0;
    bit    burst_mode = 1'b0;
    int    transfers = 0;
    int    notes_seen = 0;
    int    cfg_writes = 0;
    int    failures = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #1600000;
        $display("FAILURE");
        $finish;
    end

    task automatic apply_command(input t_cmd c);
        int n;
        int hit;
        logic signed [VALUE_W-1:0] ev;
        hit = -1;
        n = (voice_count > DEF_MAX_VOICES) ? DEF_MAX_VOICES : int'(voice_count);
        if (c.opcode == OP_SET_VALUE) begin
            held_val = c.value;
        end else if (c.opcode != OP_UNUSED) begin
            ev = (c.opcode == OP_PAD_HELD) ? held_val : c.value;
            held_val = NO_VALUE;
            for (int i = 0; i < n; i++) begin
                if (hit < 0 && voice_claimed[i] && voice_pad[i] == c.pad) hit = i;
            end
            if (hit < 0) begin
                for (int i = 0; i < n; i++) begin
                    if (hit < 0 && !voice_claimed[i]) begin
                        hit = i;
                        voice_claimed[i] = 1'b1;
                        voice_pad[i] = c.pad;
                    end
                end
            end
            if (hit >= 0 && ev >= 0) begin
                notes_due.push_back({VOICE_W'(hit), c.pad, ev[OUT_VALUE_W-1:0]});
            end
            if (hit >= 0 && ev == 0) begin
                voice_claimed[hit] = 1'b0;
                voice_pad[hit] = '0;
            end
        end
    endtask

    // Mostly back-to-back, sometimes a short pause, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                apply_command(cur_cmd);
                transfers++;
            end
            if (start && busy) begin
                // The current command stays on the bus until its transfer.
            end else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (cmd_queue.size() != 0) begin
                cur_cmd = cmd_queue.pop_front();
                i_opcode <= cur_cmd.opcode;
                i_pad <= cur_cmd.pad;
                i_value <= cur_cmd.value;
                start <= 1'b1;
                gap_left = pick_gap();
            end else begin
                start <= 1'b0;
            end
        end
    end

    task automatic report_mismatch(input string what);
        failures++;
        if (failures <= MAX_REPORTS) $display("mismatch: %s", what);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            notes_seen++;
            if (notes_due.size() == 0) begin
                report_mismatch($sformatf("unexpected note voice=%0d pad=%0d value=%0d",
                                          o_voice, o_pad_out, o_value_out));
            end else begin
                seen_note = notes_due.pop_front();
                if (o_voice !== seen_note.voice || o_pad_out !== seen_note.pad
                        || o_value_out !== seen_note.value) begin
                    report_mismatch($sformatf(
                        "expected voice=%0d pad=%0d value=%0d, got voice=%0d pad=%0d value=%0d",
                        seen_note.voice, seen_note.pad, seen_note.value,
                        o_voice, o_pad_out, o_value_out));
                end
            end
        end
    end

    task automatic push_cmd(input logic [1:0] op, input int pad, input int val);
        cmd_queue.push_back({op, PAD_W'(pad), VALUE_W'(val)});
    endtask

    // Waits for the queue to empty, every note to arrive and the pipeline to settle.
    task automatic drain();
        while (cmd_queue.size() != 0 || start) @(posedge i_clk);
        while (notes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_voice_count(input int count);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= CFG_W'(count);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        voice_count = CFG_W'(count);
        cfg_writes++;
    endtask

    function automatic int pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return $urandom_range(1, 255);
        if (r < 80) return 0;
        if (r < 90) return -1;
        return int'($urandom_range(0, 254)) - 256;
    endfunction

    // Pads come mostly from a small pool so that events find their voices again.
    task automatic queue_random(input int count, input int pad_mask);
        int left;
        int r;
        int pad;
        left = count;
        while (left > 0) begin
            r = $urandom_range(0, 99);
            pad = pad_mask ^ $urandom_range(0, 15);
            if (r < 45) begin
                push_cmd(OP_PAD_OWN, pad, pick_value());
                left--;
            end else if (r < 75) begin
                push_cmd(OP_SET_VALUE, $urandom_range(0, 255), pick_value());
                push_cmd(OP_PAD_HELD, pad, $urandom_range(0, 511));
                left -= 2;
            end else if (r < 85) begin
                push_cmd(OP_PAD_HELD, pad, $urandom_range(0, 511));
                left--;
            end else if (r < 90) begin
                push_cmd(OP_SET_VALUE, $urandom_range(0, 255), pick_value());
                left--;
            end else if (r < 94) begin
                push_cmd(OP_UNUSED, $urandom_range(0, 255), $urandom_range(0, 511));
            end else begin
                push_cmd(OP_PAD_OWN, $urandom_range(0, 255), pick_value());
                left--;
            end
        end
    endtask

    int phase_counts[10] = '{5, 48, 1, 63, 12, 2, 33, 8, 48, 20};

    initial begin
        for (int i = 0; i < DEF_MAX_VOICES; i++) begin
            voice_claimed[i] = 1'b0;
            voice_pad[i] = '0;
        end
        held_val = NO_VALUE;
        voice_count = RESET_VOICES;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Full table: claim, re-find, release, release of an unheld pad.
        push_cmd(OP_PAD_OWN, 0, 255);
        push_cmd(OP_PAD_OWN, 255, 1);
        push_cmd(OP_PAD_OWN, 0, 128);
        push_cmd(OP_PAD_OWN, 0, 0);
        push_cmd(OP_PAD_OWN, 77, 0);
        push_cmd(OP_SET_VALUE, 8'hAA, 100);
        push_cmd(OP_PAD_HELD, 5, 0);
        // The held value was consumed, so this event claims a voice silently.
        push_cmd(OP_PAD_HELD, 6, 255);
        push_cmd(OP_PAD_OWN, 6, 0);
        push_cmd(OP_UNUSED, 255, 255);
        push_cmd(OP_PAD_OWN, 9, -256);
        push_cmd(OP_PAD_OWN, 10, -2);
        push_cmd(OP_SET_VALUE, 0, -1);
        push_cmd(OP_PAD_HELD, 11, 0);
        push_cmd(OP_SET_VALUE, 0, 255);
        push_cmd(OP_PAD_OWN, 12, 7);
        push_cmd(OP_PAD_HELD, 12, 0);
        drain();

        // A single voice, already taken: the other pad finds no free voice.
        write_voice_count(1);
        push_cmd(OP_PAD_OWN, 3, 10);
        push_cmd(OP_PAD_OWN, 5, 0);
        push_cmd(OP_PAD_OWN, 3, 10);
        push_cmd(OP_PAD_OWN, 4, 20);
        drain();

        write_voice_count(0);
        push_cmd(OP_PAD_OWN, 3, 10);
        push_cmd(OP_SET_VALUE, 0, 50);
        push_cmd(OP_PAD_HELD, 4, 0);
        drain();

        write_voice_count(63);
        push_cmd(OP_PAD_OWN, 40, 9);
        push_cmd(OP_PAD_OWN, 3, 0);
        drain();

        for (int p = 0; p < 10; p++) begin
            write_voice_count(phase_counts[p]);
            burst_mode = (p % 4 == 3);
            queue_random(180, $urandom_range(0, 255));
            drain();
        end

        if (notes_due.size() != 0) begin
            failures += notes_due.size();
            $display("%0d expected notes never arrived", notes_due.size());
        end
        $display("Covered %0d command transfers and %0d notes over %0d voice-count settings.",
                 transfers, notes_seen, cfg_writes + 1);
        $display("Mismatches and missing notes: %0d", failures);
        if (failures == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- poly_voice_allocator.f -----
rtl/pva_pkg.sv
rtl/pva_front.sv
rtl/pva_queue.sv
rtl/pva_back.sv
rtl/poly_voice_allocator.sv
rtl/pva_checker.sv
tb/tb.sv
